// ===== hw/rtl/rdtq_pkg.sv =====
package rdtq_pkg;

    // fixed sizes: thread space, default node pool, key width and one tick's result burst
    localparam int THREADS   = 32;
    localparam int NODES_DEF = 64;
    localparam int MAX_RES   = 32;
    localparam int RES_IW    = $clog2(MAX_RES);
    localparam int RES_CW    = $clog2(MAX_RES + 1);
    localparam int KEY_W     = 32;

    // command codes
    localparam logic [2:0] CMD_READY_INSERT = 3'd0;
    localparam logic [2:0] CMD_READY_POP    = 3'd1;
    localparam logic [2:0] CMD_READY_REMOVE = 3'd2;
    localparam logic [2:0] CMD_TIMER_INSERT = 3'd3;
    localparam logic [2:0] CMD_TIMER_REMOVE = 3'd4;
    localparam logic [2:0] CMD_TICK         = 3'd5;
    localparam logic [2:0] CMD_SWITCH_CHECK = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_POOL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // node payload without the link field
    typedef struct packed {
        logic [4:0]       thread;
        logic [KEY_W-1:0] key;
        logic [7:0]       prio;
        logic [7:0]       tag;
    } t_node_fix;

    // per-field write enables of the node store
    typedef struct packed {
        logic thread;
        logic key;
        logic prio;
        logic tag;
        logic link;
    } t_node_we;

    // one expired thread waiting to be reported
    typedef struct packed {
        logic [4:0] thread;
        logic [7:0] tag;
    } t_res;

endpackage

// ===== hw/rtl/ready_and_delta_timer_queue_core.sv =====
// channel   | direction | handshake                 | payload
// command   | in        | start, busy               | cmd, thread_id, priority_req, wait_ticks,
//           |           |                           | resource_tag, running_priority
// result    | out       | o_valid strobe, o_last    | out_thread, out_tag, status,
//           |           |                           | switch_needed, counts, time_now
//
// a transaction is taken when start is high and busy is low; busy stays high until the
// last result of that transaction has been shown.
// each command walks linked nodes in a node memory with one read and one write port,
// one node per cycle: a pop reads the ready head, a remove or an insert walks its list,
// and a tick walks the ready list once for each node it expires, then shows its results.
// reset is synchronous; the free stack needs no clearing pass.
// results come one per cycle on consecutive cycles; the receiver cannot stall them.
module ready_and_delta_timer_queue_core import rdtq_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [4:0]  i_thread_id,
    input  logic [7:0]  i_priority_req,
    input  logic [30:0] i_wait_ticks,
    input  logic [7:0]  i_resource_tag,
    input  logic [7:0]  i_running_priority,
    output logic        o_valid,
    output logic [4:0]  o_out_thread,
    output logic [7:0]  o_out_tag,
    output logic [1:0]  o_status,
    output logic        o_switch_needed,
    output logic [6:0]  o_ready_count,
    output logic [6:0]  o_timer_count,
    output logic [62:0] o_time_now,
    output logic        o_last
);

    localparam int IW = $clog2(NODES);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(NODES + 1);
    localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_TAKE     = 5'd1;
    localparam logic [4:0] S_RL_START = 5'd2;
    localparam logic [4:0] S_RL_CHK   = 5'd3;
    localparam logic [4:0] S_RL_LINK  = 5'd4;
    localparam logic [4:0] S_RL_PREV  = 5'd5;
    localparam logic [4:0] S_RP       = 5'd6;
    localparam logic [4:0] S_FD_CHK   = 5'd7;
    localparam logic [4:0] S_TR_ADD   = 5'd8;
    localparam logic [4:0] S_TI_START = 5'd9;
    localparam logic [4:0] S_TI_CHK   = 5'd10;
    localparam logic [4:0] S_TI_WR    = 5'd11;
    localparam logic [4:0] S_TI_PREV  = 5'd12;
    localparam logic [4:0] S_TI_CUR   = 5'd13;
    localparam logic [4:0] S_TK_CHK   = 5'd14;
    localparam logic [4:0] S_TK_NEXT  = 5'd15;
    localparam logic [4:0] S_FIN      = 5'd16;
    localparam logic [4:0] S_FIN2     = 5'd17;
    localparam logic [4:0] S_PRE      = 5'd18;
    localparam logic [4:0] S_EMIT     = 5'd19;

    // control registers
    logic [4:0]        r_state, n_state;
    logic [LW-1:0]     r_rhead, n_rhead;
    logic [LW-1:0]     r_thead, n_thead;
    logic [CW-1:0]     r_rtot, n_rtot;
    logic [CW-1:0]     r_ttot, n_ttot;
    logic [62:0]       r_tick, n_tick;
    // working registers of the current transaction
    logic [2:0]        r_cmd, n_cmd;
    logic [4:0]        r_tid, n_tid;
    logic [7:0]        r_prio, n_prio;
    logic [KEY_W-1:0]  r_wait, n_wait;
    logic [7:0]        r_tag, n_tag;
    logic [7:0]        r_run, n_run;
    logic [IW-1:0]     r_node, n_node;
    logic [7:0]        r_nprio, n_nprio;
    logic [LW-1:0]     r_cur, n_cur;
    logic [LW-1:0]     r_prev, n_prev;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [RES_CW-1:0] r_k, n_k;
    logic [RES_IW-1:0] r_oi, n_oi;
    logic [4:0]        r_res_th, n_res_th;
    logic [1:0]        r_st, n_st;
    logic              r_sw, n_sw;
    logic              r_ret, n_ret;
    logic              r_first, n_first;

    // memory ports
    logic [IW-1:0]     nr_addr;
    t_node_fix         nq;
    logic [LW-1:0]     nq_link;
    t_node_we          nw_we;
    logic [IW-1:0]     nw_addr;
    t_node_fix         nw_data;
    logic [LW-1:0]     nw_link;
    logic              fs_pop, fs_push;
    logic [IW-1:0]     fs_push_node;
    logic [IW-1:0]     fs_node;
    logic              fs_empty;
    logic              rb_we;
    t_res              rb_wr;
    logic [RES_IW-1:0] rb_rd_addr;
    t_res              rb_q;

    logic [KEY_W-1:0]  tk_key;
    logic              use_buf;
    logic              emit_last;

    rdtq_node_ram #(.NODES(NODES)) u_node_ram (
        .i_clk     (i_clk),
        .i_rd_addr (nr_addr),
        .o_rd_q    (nq),
        .o_rd_link (nq_link),
        .i_we      (nw_we),
        .i_wr_addr (nw_addr),
        .i_wr_data (nw_data),
        .i_wr_link (nw_link)
    );

    rdtq_free_stack #(.NODES(NODES)) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (fs_pop),
        .i_push      (fs_push),
        .i_push_node (fs_push_node),
        .o_node      (fs_node),
        .o_empty     (fs_empty)
    );

    rdtq_res_buf u_res_buf (
        .i_clk     (i_clk),
        .i_we      (rb_we),
        .i_wr_addr (r_k[RES_IW-1:0]),
        .i_wr_data (rb_wr),
        .i_rd_addr (rb_rd_addr),
        .o_rd_q    (rb_q)
    );

    assign use_buf   = (r_k != '0);
    assign emit_last = !use_buf || ({1'b0, r_oi} == r_k - RES_CW'(1));
    // first look at the timer head on a tick sees the decremented delta
    assign tk_key    = (r_first && nq.key != '0) ? nq.key - KEY_W'(1) : nq.key;

    // result port
    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_EMIT);
    assign o_last          = emit_last;
    assign o_out_thread    = use_buf ? rb_q.thread : r_res_th;
    assign o_out_tag       = use_buf ? rb_q.tag : 8'd0;
    assign o_status        = r_st;
    assign o_switch_needed = r_sw;
    assign o_ready_count   = 7'(r_rtot);
    assign o_timer_count   = 7'(r_ttot);
    assign o_time_now      = r_tick;

    // command sequencer
    always_comb begin
        n_state  = r_state;
        n_rhead  = r_rhead;
        n_thead  = r_thead;
        n_rtot   = r_rtot;
        n_ttot   = r_ttot;
        n_tick   = r_tick;
        n_cmd    = r_cmd;
        n_tid    = r_tid;
        n_prio   = r_prio;
        n_wait   = r_wait;
        n_tag    = r_tag;
        n_run    = r_run;
        n_node   = r_node;
        n_nprio  = r_nprio;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_key    = r_key;
        n_k      = r_k;
        n_oi     = r_oi;
        n_res_th = r_res_th;
        n_st     = r_st;
        n_sw     = r_sw;
        n_ret    = r_ret;
        n_first  = r_first;
        nr_addr  = r_cur[IW-1:0];
        nw_we    = '0;
        nw_addr  = r_node;
        nw_data  = '0;
        nw_link  = r_cur;
        fs_pop   = 1'b0;
        fs_push  = 1'b0;
        fs_push_node = r_cur[IW-1:0];
        rb_we    = 1'b0;
        rb_wr    = '0;
        rb_rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_tid    = i_thread_id;
                    n_prio   = i_priority_req;
                    n_wait   = {1'b0, i_wait_ticks};
                    n_tag    = i_resource_tag;
                    n_run    = i_running_priority;
                    n_st     = ST_OK;
                    n_res_th = '0;
                    n_k      = '0;
                    n_prev   = NIL;
                    n_state  = S_FIN;
                    unique case (i_cmd)
                        CMD_READY_INSERT, CMD_TIMER_INSERT: begin
                            if (32'(i_thread_id) >= 32'(THREADS)) begin
                                n_st = ST_NOT_FOUND;
                            end else if (fs_empty) begin
                                n_st = ST_POOL;
                            end else begin
                                fs_pop  = 1'b1;
                                n_state = S_TAKE;
                            end
                        end
                        CMD_READY_POP: begin
                            if (r_rhead[LW-1]) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_cur   = r_rhead;
                                nr_addr = r_rhead[IW-1:0];
                                n_state = S_RP;
                            end
                        end
                        CMD_READY_REMOVE: begin
                            if (r_rhead[LW-1]) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_cur   = r_rhead;
                                nr_addr = r_rhead[IW-1:0];
                                n_state = S_FD_CHK;
                            end
                        end
                        CMD_TIMER_REMOVE: begin
                            if (r_thead[LW-1]) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_cur   = r_thead;
                                nr_addr = r_thead[IW-1:0];
                                n_state = S_FD_CHK;
                            end
                        end
                        CMD_TICK: begin
                            n_tick = r_tick + 63'd1;
                            if (r_thead[LW-1]) begin
                                n_st = ST_EMPTY;
                            end else begin
                                nr_addr = r_thead[IW-1:0];
                                n_first = 1'b1;
                                n_state = S_TK_CHK;
                            end
                        end
                        CMD_SWITCH_CHECK: begin
                            if (r_rhead[LW-1]) begin
                                n_st = ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // node taken from the pool
            S_TAKE: begin
                n_node = fs_node;
                n_prev = NIL;
                if (r_cmd == CMD_READY_INSERT) begin
                    nw_addr = fs_node;
                    nw_we   = '{thread: 1'b1, key: 1'b1, prio: 1'b1, tag: 1'b1, link: 1'b0};
                    nw_data = '{thread: r_tid, key: '0, prio: r_prio, tag: 8'd0};
                    n_nprio = r_prio;
                    n_cur   = r_rhead;
                    n_ret   = 1'b0;
                    n_state = S_RL_START;
                end else begin
                    n_cur   = r_thead;
                    n_state = S_TI_START;
                end
            end

            // sorted walk of the ready list
            S_RL_START: begin
                nr_addr = r_cur[IW-1:0];
                n_state = r_cur[LW-1] ? S_RL_LINK : S_RL_CHK;
            end
            S_RL_CHK: begin
                if (nq.prio <= r_nprio) begin
                    n_prev  = r_cur;
                    n_cur   = nq_link;
                    nr_addr = nq_link[IW-1:0];
                    if (nq_link[LW-1]) begin
                        n_state = S_RL_LINK;
                    end
                end else begin
                    n_state = S_RL_LINK;
                end
            end
            S_RL_LINK: begin
                nw_we.link = 1'b1;
                nw_addr    = r_node;
                nw_link    = r_cur;
                n_rtot     = r_rtot + CW'(1);
                if (r_prev[LW-1]) begin
                    n_rhead = {1'b0, r_node};
                    n_state = r_ret ? S_TK_NEXT : S_FIN;
                end else begin
                    n_state = S_RL_PREV;
                end
            end
            S_RL_PREV: begin
                nw_we.link = 1'b1;
                nw_addr    = r_prev[IW-1:0];
                nw_link    = {1'b0, r_node};
                n_state    = r_ret ? S_TK_NEXT : S_FIN;
            end

            // ready head popped
            S_RP: begin
                n_res_th = nq.thread;
                n_rhead  = nq_link;
                n_rtot   = r_rtot - CW'(1);
                fs_push  = 1'b1;
                n_state  = S_FIN;
            end

            // search by thread for either remove
            S_FD_CHK: begin
                if (nq.thread == r_tid) begin
                    fs_push = 1'b1;
                    n_state = S_FIN;
                    if (!r_prev[LW-1]) begin
                        nw_we.link = 1'b1;
                        nw_addr    = r_prev[IW-1:0];
                        nw_link    = nq_link;
                    end
                    if (r_cmd == CMD_READY_REMOVE) begin
                        n_rtot = r_rtot - CW'(1);
                        if (r_prev[LW-1]) n_rhead = nq_link;
                    end else begin
                        n_ttot = r_ttot - CW'(1);
                        if (r_prev[LW-1]) n_thead = nq_link;
                        if (!nq_link[LW-1]) begin
                            n_key   = nq.key;
                            n_cur   = nq_link;
                            nr_addr = nq_link[IW-1:0];
                            n_state = S_TR_ADD;
                        end
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = nq_link;
                    nr_addr = nq_link[IW-1:0];
                    if (nq_link[LW-1]) begin
                        n_st    = ST_NOT_FOUND;
                        n_state = S_FIN;
                    end
                end
            end
            // removed delta carried into the follower
            S_TR_ADD: begin
                nw_we.key   = 1'b1;
                nw_addr     = r_cur[IW-1:0];
                nw_data.key = nq.key + r_key;
                n_state     = S_FIN;
            end

            // delta walk of the timer list
            S_TI_START: begin
                nr_addr = r_cur[IW-1:0];
                n_state = r_cur[LW-1] ? S_TI_WR : S_TI_CHK;
            end
            S_TI_CHK: begin
                if (nq.key < r_wait) begin
                    n_wait  = r_wait - nq.key;
                    n_prev  = r_cur;
                    n_cur   = nq_link;
                    nr_addr = nq_link[IW-1:0];
                    if (nq_link[LW-1]) begin
                        n_state = S_TI_WR;
                    end
                end else begin
                    n_key   = nq.key;
                    n_state = S_TI_WR;
                end
            end
            S_TI_WR: begin
                nw_we   = '{thread: 1'b1, key: 1'b1, prio: 1'b1, tag: 1'b1, link: 1'b1};
                nw_addr = r_node;
                nw_data = '{thread: r_tid, key: r_wait, prio: r_prio, tag: r_tag};
                nw_link = r_cur;
                n_ttot  = r_ttot + CW'(1);
                if (r_prev[LW-1]) begin
                    n_thead = {1'b0, r_node};
                    n_state = r_cur[LW-1] ? S_FIN : S_TI_CUR;
                end else begin
                    n_state = S_TI_PREV;
                end
            end
            S_TI_PREV: begin
                nw_we.link = 1'b1;
                nw_addr    = r_prev[IW-1:0];
                nw_link    = {1'b0, r_node};
                n_state    = r_cur[LW-1] ? S_FIN : S_TI_CUR;
            end
            S_TI_CUR: begin
                nw_we.key   = 1'b1;
                nw_addr     = r_cur[IW-1:0];
                nw_data.key = r_key - r_wait;
                n_state     = S_FIN;
            end

            // tick expiry of the timer head
            S_TK_CHK: begin
                n_first = 1'b0;
                if (tk_key == '0) begin
                    rb_we   = 1'b1;
                    rb_wr   = '{thread: nq.thread, tag: nq.tag};
                    n_k     = r_k + RES_CW'(1);
                    n_thead = nq_link;
                    n_ttot  = r_ttot - CW'(1);
                    n_node  = r_thead[IW-1:0];
                    n_nprio = nq.prio;
                    n_cur   = r_rhead;
                    n_prev  = NIL;
                    n_ret   = 1'b1;
                    n_state = S_RL_START;
                end else begin
                    if (r_first) begin
                        nw_we.key   = 1'b1;
                        nw_addr     = r_thead[IW-1:0];
                        nw_data.key = tk_key;
                    end
                    n_st    = (r_k == '0) ? ST_EMPTY : ST_OK;
                    n_state = S_FIN;
                end
            end
            S_TK_NEXT: begin
                nr_addr = r_thead[IW-1:0];
                if (r_thead[LW-1] || r_k == RES_CW'(MAX_RES)) begin
                    n_st    = ST_OK;
                    n_state = S_FIN;
                end else begin
                    n_state = S_TK_CHK;
                end
            end

            // switch check against the final ready head
            S_FIN: begin
                nr_addr = r_rhead[IW-1:0];
                if (r_rhead[LW-1]) begin
                    n_sw    = 1'b0;
                    n_state = S_PRE;
                end else begin
                    n_state = S_FIN2;
                end
            end
            S_FIN2: begin
                n_sw    = (nq.prio < r_run);
                n_state = S_PRE;
            end

            // result burst
            S_PRE: begin
                rb_rd_addr = '0;
                n_oi       = '0;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                rb_rd_addr = r_oi + RES_IW'(1);
                n_oi       = r_oi + RES_IW'(1);
                if (emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rhead <= NIL;
            r_thead <= NIL;
            r_rtot  <= '0;
            r_ttot  <= '0;
            r_tick  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_rhead <= n_rhead;
            r_thead <= n_thead;
            r_rtot  <= n_rtot;
            r_ttot  <= n_ttot;
            r_tick  <= n_tick;
            r_k     <= n_k;
        end
    end

    // transaction working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_tid    <= n_tid;
        r_prio   <= n_prio;
        r_wait   <= n_wait;
        r_tag    <= n_tag;
        r_run    <= n_run;
        r_node   <= n_node;
        r_nprio  <= n_nprio;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_key    <= n_key;
        r_oi     <= n_oi;
        r_res_th <= n_res_th;
        r_st     <= n_st;
        r_sw     <= n_sw;
        r_ret    <= n_ret;
        r_first  <= n_first;
    end

    // results of one transaction come back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("result burst broken");

    // lists never hold more nodes than the pool has
    a_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_rtot) + 32'(r_ttot)) <= 32'(NODES))
        else $error("node count exceeds pool");

    // an empty ready list has a null head
    a_rhead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rtot == '0) == r_rhead[LW-1])
        else $error("ready head and count disagree");

    // an empty timer list has a null head
    a_thead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ttot == '0) == r_thead[LW-1])
        else $error("timer head and count disagree");

endmodule

// ===== hw/rtl/rdtq_node_ram.sv =====
module rdtq_node_ram import rdtq_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                       i_clk,
    input  logic [$clog2(NODES)-1:0]   i_rd_addr,
    output t_node_fix                  o_rd_q,
    output logic [$clog2(NODES):0]     o_rd_link,
    input  t_node_we                   i_we,
    input  logic [$clog2(NODES)-1:0]   i_wr_addr,
    input  t_node_fix                  i_wr_data,
    input  logic [$clog2(NODES):0]     i_wr_link
);

    localparam int IW = $clog2(NODES);
    localparam int LW = IW + 1;

    logic [4:0]       r_thread [NODES];
    logic [KEY_W-1:0] r_key    [NODES];
    logic [7:0]       r_prio   [NODES];
    logic [7:0]       r_tag    [NODES];
    logic [LW-1:0]    r_link   [NODES];

    // field-masked write port
    always_ff @(posedge i_clk) begin
        if (i_we.thread) r_thread[i_wr_addr] <= i_wr_data.thread;
        if (i_we.key)    r_key[i_wr_addr]    <= i_wr_data.key;
        if (i_we.prio)   r_prio[i_wr_addr]   <= i_wr_data.prio;
        if (i_we.tag)    r_tag[i_wr_addr]    <= i_wr_data.tag;
        if (i_we.link)   r_link[i_wr_addr]   <= i_wr_link;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_q.thread <= r_thread[i_rd_addr];
        o_rd_q.key    <= r_key[i_rd_addr];
        o_rd_q.prio   <= r_prio[i_rd_addr];
        o_rd_q.tag    <= r_tag[i_rd_addr];
        o_rd_link     <= r_link[i_rd_addr];
    end

endmodule

// ===== hw/rtl/rdtq_free_stack.sv =====
module rdtq_free_stack import rdtq_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_pop,
    input  logic                     i_push,
    input  logic [$clog2(NODES)-1:0] i_push_node,
    output logic [$clog2(NODES)-1:0] o_node,
    output logic                     o_empty
);

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    logic [IW-1:0] r_mem [NODES];
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_low;
    logic [IW-1:0] r_q;
    logic [IW-1:0] r_rd_addr;
    logic          r_fresh;
    logic [CW-1:0] top_idx;

    assign top_idx = r_count - CW'(1);
    assign o_empty = (r_count == '0);
    // entries below the low mark were never written and hold their own index
    assign o_node  = r_fresh ? r_rd_addr : r_q;

    // fill count and low-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(NODES);
            r_low   <= CW'(NODES);
        end else if (i_pop) begin
            r_count <= top_idx;
            if (top_idx < r_low) begin
                r_low <= top_idx;
            end
        end else if (i_push) begin
            r_count <= r_count + CW'(1);
        end
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_count[IW-1:0]] <= i_push_node;
        end
        if (i_pop) begin
            r_q       <= r_mem[top_idx[IW-1:0]];
            r_rd_addr <= top_idx[IW-1:0];
            r_fresh   <= (top_idx < r_low);
        end
    end

endmodule

// ===== hw/rtl/rdtq_res_buf.sv =====
module rdtq_res_buf import rdtq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [RES_IW-1:0] i_wr_addr,
    input  t_res              i_wr_data,
    input  logic [RES_IW-1:0] i_rd_addr,
    output t_res              o_rd_q
);

    t_res r_mem [MAX_RES];

    // expired threads of one tick, read back in order
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_q <= r_mem[i_rd_addr];
    end

endmodule
